@@ design/mat_pkg.sv @@
package mat_pkg;

	localparam int WINDOW_DEFAULT      = 100;
	localparam int SAMPLE_BITS_DEFAULT = 12;

	localparam int AVG_BITS       = 12;
	localparam int THR_BITS       = 12;
	localparam int HOLD_BITS      = 16;
	localparam int ELAPSED_BITS   = 16;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 16;

	localparam logic [THR_BITS-1:0]  THRESHOLD_RESET = THR_BITS'(3000);
	localparam logic [HOLD_BITS-1:0] HOLD_RESET      = HOLD_BITS'(300);

	localparam logic [CFG_INDEX_BITS-1:0] CFG_ON_THRESHOLD = CFG_INDEX_BITS'(0);
	localparam logic [CFG_INDEX_BITS-1:0] CFG_HOLD_SAMPLES = CFG_INDEX_BITS'(1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RING,
		ST_DIV,
		ST_OUT
	} state_t;

endpackage

@@ design/mat_ring.sv @@
module mat_ring #(
	parameter int WINDOW      = mat_pkg::WINDOW_DEFAULT,
	parameter int SAMPLE_BITS = mat_pkg::SAMPLE_BITS_DEFAULT,
	localparam int CNT_BITS   = $clog2(WINDOW + 1),
	localparam int SUM_BITS   = SAMPLE_BITS + CNT_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic                   done,
	output logic [SUM_BITS-1:0]    sum,
	output logic [CNT_BITS-1:0]    fill
);

	localparam int IDX_BITS = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(WINDOW - 1);
	localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(WINDOW);

	logic [SAMPLE_BITS-1:0] mem [WINDOW];
	logic [SAMPLE_BITS-1:0] old_q;
	logic [SAMPLE_BITS-1:0] sample_q;
	logic [IDX_BITS-1:0]    idx_q;
	logic [CNT_BITS-1:0]    fill_q;
	logic [SUM_BITS-1:0]    sum_q;
	logic                   phase_q;
	logic                   done_q;
	logic                   full;
	logic [SUM_BITS-1:0]    drop;

	assign full = (fill_q == FULL_CNT);
	assign drop = full ? SUM_BITS'(old_q) : '0;

	// entry being replaced is read at the transfer and written in the cycle after it
	always_ff @(posedge clk) begin
		if (start) begin
			old_q    <= mem[idx_q];
			sample_q <= sample;
		end
		if (phase_q) begin
			mem[idx_q] <= sample_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			fill_q  <= '0;
			sum_q   <= '0;
			phase_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			phase_q <= start;
			done_q  <= phase_q;
			if (phase_q) begin
				sum_q <= sum_q - drop + SUM_BITS'(sample_q);
				if (!full) begin
					fill_q <= fill_q + CNT_BITS'(1);
				end
				idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + IDX_BITS'(1);
			end
		end
	end

	assign done = done_q;
	assign sum  = sum_q;
	assign fill = fill_q;

endmodule

@@ design/mat_div.sv @@
module mat_div #(
	parameter int DIVIDEND_BITS = 19,
	parameter int DIVISOR_BITS  = 7
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [DIVIDEND_BITS-1:0] dividend,
	input  logic [DIVISOR_BITS-1:0]  divisor,
	output logic                     done,
	output logic [DIVIDEND_BITS-1:0] quotient
);

	localparam int STEP_BITS = $clog2(DIVIDEND_BITS + 1);
	localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(DIVIDEND_BITS - 1);

	logic [DIVIDEND_BITS-1:0] quo_q;
	logic [DIVISOR_BITS-1:0]  rem_q;
	logic [DIVISOR_BITS-1:0]  divisor_q;
	logic [STEP_BITS-1:0]     step_q;
	logic                     busy_q;
	logic                     done_q;
	logic [DIVISOR_BITS:0]    trial;
	logic [DIVISOR_BITS:0]    diff;
	logic                     fits;

	// restoring division, one quotient bit per cycle; dividend shifts out as quotient shifts in
	assign trial = {rem_q, quo_q[DIVIDEND_BITS-1]};
	assign diff  = trial - {1'b0, divisor_q};
	assign fits  = (trial >= {1'b0, divisor_q});

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q     <= dividend;
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
			if (DIVIDEND_BITS > 1) begin
				quo_q <= {quo_q[DIVIDEND_BITS-2:0], fits};
			end else begin
				quo_q <= DIVIDEND_BITS'(fits);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_BITS'(1);
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ design/moving_average_threshold_hold.sv @@
// Moving average threshold detector with hold.
// Sample channel: sample with sample_valid / sample_stall; a sample transfers on
// a rising edge with valid high and stall low. Result channel: average and
// enabled with result_valid / result_stall, driven from an output register.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; index 0
// writes on_threshold, index 1 writes hold_samples, other indexes are ignored.
// cfg_ready is always high; write only while the block is idle.
// One sample is processed at a time: the ring update, then the bit-serial
// divider, which takes one quotient bit per cycle over the sum width
// (SAMPLE_BITS + clog2(WINDOW+1)); a new sample is taken in the cycle after
// the result is loaded into the output register.
// While result_stall holds a result, the next sample is still accepted and
// processed; it waits in the last step until the output register frees up.
// Reset clears the window fill count, running sum and elapsed counter and loads
// on_threshold 3000 and hold_samples 300; window entries are not cleared and
// are never read before being written. enabled is not reset; the first result sets it.
module moving_average_threshold_hold #(
	parameter int WINDOW      = mat_pkg::WINDOW_DEFAULT,
	parameter int SAMPLE_BITS = mat_pkg::SAMPLE_BITS_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               sample_valid,
	output logic                               sample_stall,
	input  logic [SAMPLE_BITS-1:0]             sample,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic [mat_pkg::AVG_BITS-1:0]       average,
	output logic                               enabled,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [mat_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [mat_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int CNT_BITS = $clog2(WINDOW + 1);
	localparam int SUM_BITS = SAMPLE_BITS + CNT_BITS;
	localparam int EXT_BITS = SUM_BITS + mat_pkg::AVG_BITS + mat_pkg::HOLD_BITS;

	mat_pkg::state_t state_q, state_d;

	logic [mat_pkg::THR_BITS-1:0]     thr_q;
	logic [mat_pkg::HOLD_BITS-1:0]    hold_q;
	logic [mat_pkg::ELAPSED_BITS-1:0] elapsed_q;
	logic [mat_pkg::ELAPSED_BITS-1:0] elapsed_d;
	logic [mat_pkg::AVG_BITS-1:0]     average_q;
	logic                             enabled_q;
	logic                             result_valid_q;

	logic                ring_start;
	logic                ring_done;
	logic [SUM_BITS-1:0] ring_sum;
	logic [CNT_BITS-1:0] ring_fill;
	logic                div_start;
	logic                div_done;
	logic [SUM_BITS-1:0] quotient;
	logic [EXT_BITS-1:0] quo_ext;
	logic                load;
	logic                out_free;

	mat_ring #(
		.WINDOW      (WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ring_start),
		.sample (sample),
		.done   (ring_done),
		.sum    (ring_sum),
		.fill   (ring_fill)
	);

	mat_div #(
		.DIVIDEND_BITS (SUM_BITS),
		.DIVISOR_BITS  (CNT_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (ring_sum),
		.divisor  (ring_fill),
		.done     (div_done),
		.quotient (quotient)
	);

	assign out_free = !result_valid_q || !result_stall;
	assign quo_ext  = EXT_BITS'(quotient);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mat_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		sample_stall = 1'b1;
		ring_start   = 1'b0;
		div_start    = 1'b0;
		load         = 1'b0;
		unique case (state_q)
			mat_pkg::ST_IDLE: begin
				sample_stall = 1'b0;
				if (sample_valid) begin
					ring_start = 1'b1;
					state_d    = mat_pkg::ST_RING;
				end
			end
			mat_pkg::ST_RING: begin
				if (ring_done) begin
					div_start = 1'b1;
					state_d   = mat_pkg::ST_DIV;
				end
			end
			mat_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = mat_pkg::ST_OUT;
				end
			end
			mat_pkg::ST_OUT: begin
				if (out_free) begin
					load    = 1'b1;
					state_d = mat_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mat_pkg::ST_IDLE;
			end
		endcase
	end

	// the unmasked mean is compared; only the reported average is cut to 12 bits
	always_comb begin
		if (quo_ext < EXT_BITS'(thr_q)) begin
			elapsed_d = '0;
		end else if (elapsed_q != '1) begin
			elapsed_d = elapsed_q + mat_pkg::ELAPSED_BITS'(1);
		end else begin
			elapsed_d = elapsed_q;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			average_q <= quo_ext[mat_pkg::AVG_BITS-1:0];
			enabled_q <= (elapsed_d < hold_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q          <= mat_pkg::THRESHOLD_RESET;
			hold_q         <= mat_pkg::HOLD_RESET;
			elapsed_q      <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == mat_pkg::CFG_ON_THRESHOLD) begin
					thr_q <= cfg_data[mat_pkg::THR_BITS-1:0];
				end else if (cfg_index == mat_pkg::CFG_HOLD_SAMPLES) begin
					hold_q <= cfg_data[mat_pkg::HOLD_BITS-1:0];
				end
			end
			if (load) begin
				elapsed_q      <= elapsed_d;
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign average      = average_q;
	assign enabled      = enabled_q;

endmodule

@@ sim/mat_checker.sv @@
`timescale 1ns / 1ps

module mean_hold_checker #(
	parameter int WINDOW      = mat_pkg::WINDOW_DEFAULT,
	parameter int SAMPLE_BITS = mat_pkg::SAMPLE_BITS_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               sample_valid,
	input  logic                               sample_stall,
	input  logic [SAMPLE_BITS-1:0]             sample,
	input  logic                               result_valid,
	input  logic                               result_stall,
	input  logic [mat_pkg::AVG_BITS-1:0]       average,
	input  logic                               enabled,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [mat_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [mat_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	output int                                 errors,
	output int                                 pending,
	output int                                 samples_seen,
	output int                                 results_seen,
	output int                                 writes_seen,
	output int                                 enabled_high,
	output int                                 input_stalls
);

	localparam int SUM_BITS    = SAMPLE_BITS + $clog2(WINDOW + 1);
	localparam int REPORT_MAX  = 10;

	typedef struct packed {
		logic [mat_pkg::AVG_BITS-1:0] average;
		logic                         enabled;
	} mean_result_t;

	mean_result_t                     expected_means [$];
	logic [SAMPLE_BITS-1:0]           window_ring [WINDOW];
	logic [SUM_BITS-1:0]              window_sum;
	int                               ring_fill;
	int                               ring_ptr;
	logic [mat_pkg::THR_BITS-1:0]     on_thr;
	logic [mat_pkg::HOLD_BITS-1:0]    hold_len;
	logic [mat_pkg::ELAPSED_BITS-1:0] since_low;

	int mismatch_count;
	int stray_count;
	int sample_count;
	int result_count;
	int write_count;
	int high_count;
	int stall_count;

	initial begin
		errors       = 0;
		pending      = 0;
		samples_seen = 0;
		results_seen = 0;
		writes_seen  = 0;
		enabled_high = 0;
		input_stalls = 0;
	end

	always @(posedge clk or negedge arst_n) begin : track
		mean_result_t want;
		int           mean;
		if (!arst_n) begin
			expected_means.delete();
			window_sum     = '0;
			ring_fill      = 0;
			ring_ptr       = 0;
			on_thr         = mat_pkg::THRESHOLD_RESET;
			hold_len       = mat_pkg::HOLD_RESET;
			since_low      = '0;
			mismatch_count = 0;
			stray_count    = 0;
			sample_count   = 0;
			result_count   = 0;
			write_count    = 0;
			high_count     = 0;
			stall_count    = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == mat_pkg::CFG_ON_THRESHOLD) begin
					on_thr = cfg_data[mat_pkg::THR_BITS-1:0];
				end else if (cfg_index == mat_pkg::CFG_HOLD_SAMPLES) begin
					hold_len = cfg_data[mat_pkg::HOLD_BITS-1:0];
				end
				write_count++;
			end

			if (sample_valid && sample_stall)
				stall_count++;

			if (sample_valid && !sample_stall) begin
				// once the window is full the oldest entry leaves the sum
				if (ring_fill == WINDOW)
					window_sum = window_sum - SUM_BITS'(window_ring[ring_ptr]);
				else
					ring_fill++;
				window_ring[ring_ptr] = sample;
				window_sum = window_sum + SUM_BITS'(sample);
				ring_ptr = (ring_ptr == WINDOW - 1) ? 0 : ring_ptr + 1;

				mean = int'(window_sum) / ring_fill;
				if (mean < int'(on_thr))
					since_low = '0;
				else if (since_low != '1)
					since_low = since_low + mat_pkg::ELAPSED_BITS'(1);

				want.average = mat_pkg::AVG_BITS'(mean);
				want.enabled = (since_low < hold_len);
				expected_means.insert(expected_means.size(), want);
				sample_count++;
			end

			if (result_valid && !result_stall) begin
				result_count++;
				if (enabled === 1'b1)
					high_count++;
				if (expected_means.size() == 0) begin
					if (mismatch_count + stray_count < REPORT_MAX)
						$display("[%0t] result %0d with nothing expected: average %0d enabled %b",
							$realtime, result_count, average, enabled);
					stray_count++;
				end else begin
					want = expected_means.pop_front();
					if (average !== want.average || enabled !== want.enabled) begin
						if (mismatch_count + stray_count < REPORT_MAX)
							$display("[%0t] result %0d: expected avg %0d en %b, got avg %0d en %b",
								$realtime, result_count, want.average, want.enabled, average,
								enabled);
						mismatch_count++;
					end
				end
			end
		end

		errors       <= mismatch_count + stray_count;
		pending      <= expected_means.size();
		samples_seen <= sample_count;
		results_seen <= result_count;
		writes_seen  <= write_count;
		enabled_high <= high_count;
		input_stalls <= stall_count;
	end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;

	localparam int SAMPLE_BITS      = mat_pkg::SAMPLE_BITS_DEFAULT;
	localparam int SAMPLE_MAX       = (1 << SAMPLE_BITS) - 1;
	localparam int THR_MAX          = (1 << mat_pkg::THR_BITS) - 1;
	localparam int HOLD_MAX         = (1 << mat_pkg::HOLD_BITS) - 1;
	localparam int RESET_CYCLES     = 12;
	localparam int SETTLE_CYCLES    = 40;
	localparam int HOLD_OFF_CYCLES  = 600;
	localparam int PHASE_ITEMS      = 380;
	localparam int PRESSURE_ITEMS   = 150;
	// threshold of zero keeps every mean high so the elapsed counter only climbs
	localparam int LONG_RUN_ITEMS   = 200;
	localparam longint RUN_LIMIT_NS = 100_000_000;

	// indexes past the two registers, which the block must ignore
	localparam logic [mat_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_A = mat_pkg::CFG_INDEX_BITS'(2);
	localparam logic [mat_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_B = mat_pkg::CFG_INDEX_BITS'(3);

	typedef enum {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	logic                                clk          = 1'b0;
	logic                                arst_n       = 1'b0;
	logic                                sample_valid = 1'b0;
	logic                                sample_stall;
	logic [SAMPLE_BITS-1:0]              sample       = '0;
	logic                                result_valid;
	logic                                result_stall = 1'b0;
	logic [mat_pkg::AVG_BITS-1:0]        average;
	logic                                enabled;
	logic                                cfg_valid    = 1'b0;
	logic                                cfg_ready;
	logic [mat_pkg::CFG_INDEX_BITS-1:0]  cfg_index    = '0;
	logic [mat_pkg::CFG_DATA_BITS-1:0]   cfg_data     = '0;

	idle_mode_t idle_mode      = IDLE_NONE;
	logic       pressure_req   = 1'b0;
	logic       pressure_taken = 1'b0;
	int         hold_off_left  = 0;
	int         cur_thr        = int'(mat_pkg::THRESHOLD_RESET);

	int errors;
	int pending;
	int samples_seen;
	int results_seen;
	int writes_seen;
	int enabled_high;
	int input_stalls;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	moving_average_threshold_hold dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.average      (average),
		.enabled      (enabled),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	mean_hold_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.average      (average),
		.enabled      (enabled),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.errors       (errors),
		.pending      (pending),
		.samples_seen (samples_seen),
		.results_seen (results_seen),
		.writes_seen  (writes_seen),
		.enabled_high (enabled_high),
		.input_stalls (input_stalls)
	);

	function automatic int idle_pct(input idle_mode_t mode, input bit sender_side);
		case (mode)
			IDLE_SENDER:   return sender_side ? 87 : 0;
			IDLE_RECEIVER: return sender_side ? 0 : 87;
			IDLE_BOTH:     return 30;
			default:       return 0;
		endcase
	endfunction

	// result side: random stall, plus one long hold-off on request
	always @(posedge clk) begin
		if (pressure_req && !pressure_taken) begin
			pressure_taken <= 1'b1;
			hold_off_left  <= HOLD_OFF_CYCLES;
			result_stall   <= 1'b1;
		end else if (hold_off_left != 0) begin
			hold_off_left <= hold_off_left - 1;
			result_stall  <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99, 0) < idle_pct(idle_mode, 1'b0));
		end
	end

	// valid stays high from one transfer into the next unless a gap is drawn
	task automatic send_sample(input logic [SAMPLE_BITS-1:0] value);
		while ($urandom_range(99, 0) < idle_pct(idle_mode, 1'b1)) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= value;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
	endtask

	task automatic drain();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [mat_pkg::CFG_INDEX_BITS-1:0] idx,
			input logic [mat_pkg::CFG_DATA_BITS-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
		if (idx == mat_pkg::CFG_ON_THRESHOLD)
			cur_thr = int'(data[mat_pkg::THR_BITS-1:0]);
	endtask

	// upper data bits are random so that the bits above the threshold width toggle
	task automatic configure(input int thr, input int hold);
		write_reg(mat_pkg::CFG_ON_THRESHOLD,
			{4'($urandom_range(15, 0)), mat_pkg::THR_BITS'(thr)});
		write_reg(mat_pkg::CFG_HOLD_SAMPLES, mat_pkg::CFG_DATA_BITS'(hold));
	endtask

	// runs around a level so the mean settles, crosses the threshold and the hold expires
	task automatic send_level_runs(input int count);
		int sent;
		int run_len;
		int level;
		int spread;
		int v;
		sent = 0;
		while (sent < count) begin
			run_len = $urandom_range(150, 10);
			spread  = $urandom_range(600, 0);
			case ($urandom_range(3, 0))
				0:       level = cur_thr - int'($urandom_range(300, 0));
				1:       level = cur_thr + int'($urandom_range(300, 0));
				2:       level = int'($urandom_range(SAMPLE_MAX, 0));
				default: level = $urandom_range(1, 0) ? 0 : SAMPLE_MAX;
			endcase
			for (int i = 0; i < run_len && sent < count; i++) begin
				if ($urandom_range(99, 0) < 12)
					v = int'($urandom_range(SAMPLE_MAX, 0));
				else
					v = level + int'($urandom_range(2 * spread, 0)) - spread;
				if (v < 0)
					v = 0;
				else if (v > SAMPLE_MAX)
					v = SAMPLE_MAX;
				send_sample(SAMPLE_BITS'(v));
				sent++;
			end
		end
	endtask

	initial begin
		#(RUN_LIMIT_NS);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin : stimulus
		logic [SAMPLE_BITS-1:0] after_reset [13];
		after_reset = '{12'hFFF, 12'hFFF, 12'hFFF, 12'h000, 12'h000, 12'h000, 12'h000,
			12'd2999, 12'd3000, 12'hAAA, 12'h555, 12'h001, 12'h800};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset register values, enabled from the first sample
		foreach (after_reset[i])
			send_sample(after_reset[i]);
		drain();

		// zero hold keeps enabled low; high data bits must be dropped
		write_reg(mat_pkg::CFG_ON_THRESHOLD, 16'hFFFF);
		write_reg(mat_pkg::CFG_HOLD_SAMPLES, 16'h0000);
		send_sample(12'hFFF);
		send_sample(12'h000);
		drain();

		// unused indexes change nothing
		write_reg(CFG_SPARE_A, 16'h0000);
		write_reg(CFG_SPARE_B, 16'hFFFF);
		send_sample(12'h7FF);
		drain();

		// zero threshold means no mean is ever low, hold of one drops enabled at once
		write_reg(mat_pkg::CFG_ON_THRESHOLD, 16'hF000);
		write_reg(mat_pkg::CFG_HOLD_SAMPLES, 16'h0001);
		send_sample(12'h000);
		send_sample(12'hFFF);
		send_sample(12'h123);
		drain();

		write_reg(mat_pkg::CFG_ON_THRESHOLD, 16'd2000);
		write_reg(mat_pkg::CFG_HOLD_SAMPLES, 16'd2);
		repeat (4) send_sample(12'hFFF);
		drain();

		idle_mode <= IDLE_NONE;
		configure($urandom_range(THR_MAX, 0), $urandom_range(200, 1));
		send_level_runs(PHASE_ITEMS);
		drain();

		idle_mode <= IDLE_SENDER;
		configure(0, $urandom_range(120, 0));
		send_level_runs(PHASE_ITEMS);
		drain();

		idle_mode <= IDLE_RECEIVER;
		configure(THR_MAX, HOLD_MAX);
		send_level_runs(PHASE_ITEMS);
		drain();

		idle_mode <= IDLE_BOTH;
		configure($urandom_range(THR_MAX, 0), $urandom_range(60, 0));
		send_level_runs(PHASE_ITEMS);
		drain();

		// long hold-off on the result side while samples keep coming
		idle_mode <= IDLE_NONE;
		configure($urandom_range(THR_MAX, 0), $urandom_range(200, 1));
		pressure_req <= 1'b1;
		send_level_runs(PRESSURE_ITEMS);
		drain();

		configure(0, HOLD_MAX);
		repeat (LONG_RUN_ITEMS) send_sample(SAMPLE_BITS'($urandom_range(SAMPLE_MAX, 0)));
		drain();

		$display("%0d samples and %0d register writes transferred, %0d results compared",
			samples_seen, writes_seen, results_seen);
		$display("enabled high in %0d results, sample input held off for %0d cycles",
			enabled_high, input_stalls);
		if (errors == 0 && pending == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

@@ moving_average_threshold_hold.f @@
design/mat_pkg.sv
design/mat_ring.sv
design/mat_div.sv
design/moving_average_threshold_hold.sv
sim/mat_checker.sv
sim/tb.sv
